// ===== src/assert_macros.svh =====
// assertion helpers for the element walker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge outside reset
`define BEW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BEW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/bew_pkg.sv =====
package bew_pkg;

  typedef enum logic [2:0] {
    PH_IDLE, PH_DOCLEN, PH_TYPE, PH_NAME, PH_LENF, PH_SUBTYPE, PH_SKIP
  } phase_t;

  localparam logic [2:0] EV_ELEM    = 3'd0;
  localparam logic [2:0] EV_END     = 3'd1;
  localparam logic [2:0] EV_SHORT   = 3'd2;
  localparam logic [2:0] EV_OVERRUN = 3'd3;
  localparam logic [2:0] EV_SUBTYPE = 3'd4;
  localparam logic [2:0] EV_BADTYPE = 3'd5;

  localparam logic [7:0] T_DOUBLE = 8'h01;
  localparam logic [7:0] T_STRING = 8'h02;
  localparam logic [7:0] T_DOC    = 8'h03;
  localparam logic [7:0] T_ARRAY  = 8'h04;
  localparam logic [7:0] T_BINARY = 8'h05;
  localparam logic [7:0] T_BOOL   = 8'h08;
  localparam logic [7:0] T_NULL   = 8'h0A;
  localparam logic [7:0] T_INT32  = 8'h10;
  localparam logic [7:0] T_UINT64 = 8'h11;
  localparam logic [7:0] T_INT64  = 8'h12;
  localparam logic [7:0] T_DEC128 = 8'h13;

  localparam logic [1:0] REG_INT64  = 2'd0;
  localparam logic [1:0] REG_DEC128 = 2'd1;

  localparam int QUEUE_DEPTH = 4;

  // classified byte handed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       type_ok;
    logic       fixed;
    logic [4:0] fsize;
  } item_t;

  typedef struct packed {
    logic [2:0]  ev;
    logic [7:0]  etype;
    logic [30:0] name_off;
    logic [30:0] name_len;
    logic [30:0] data_off;
    logic [30:0] data_size;
    logic [30:0] count;
  } result_t;

  localparam int RES_W = $bits(result_t);

endpackage

// ===== src/bson_element_walker_core.sv =====
// bson element walker: takes a top-level bson document one byte per transaction
// and reports each finished element, the document end or the first error.
// a byte is taken every clock while results drain; the front stage classifies
// the type byte, a four-entry queue decouples it from the back stage, which
// tracks offsets and lengths and registers one result. the byte that completes a
// result passes the front register, then the queue, then the result register,
// where the result becomes valid; input stalls only come from a waiting result
// filling the queue. registers: 0x0 enable_int64_types, 0x4 enable_decimal128,
// both reset to 1.
module bson_element_walker_core #(
  parameter int QDEPTH = bew_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // data_byte
  input  logic         in_tuser,   // first_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [167:0] out_tdata,  // event_res, elem_type, name_offset, name_length,
                                   // data_offset, data_size, elem_count, zero fill
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  logic en64_r, en64_nxt, en128_r, en128_nxt;
  logic           f_valid, f_ready, b_valid, b_ready;
  bew_pkg::item_t f_item, b_item;
  logic [bew_pkg::RES_W-1:0] res;
  bew_pkg::result_t rs;

  // register file, write on access phase
  assign cfg_pready = 1'b1;
  always_comb begin
    en64_nxt  = en64_r;
    en128_nxt = en128_r;
    if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_paddr[2])
        bew_pkg::REG_INT64[0]:  en64_nxt  = cfg_pwdata[0];
        bew_pkg::REG_DEC128[0]: en128_nxt = cfg_pwdata[0];
        default: ;
      endcase
    end
    case (cfg_paddr[2])
      bew_pkg::REG_INT64[0]: cfg_prdata = {31'd0, en64_r};
      default:               cfg_prdata = {31'd0, en128_r};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en64_r  <= 1'b1;
      en128_r <= 1'b1;
    end else begin
      en64_r  <= en64_nxt;
      en128_r <= en128_nxt;
    end
  end

  bew_front u_front (
    .clk, .rst_n, .en64(en64_r), .en128(en128_r),
    .s_valid(in_tvalid), .s_ready(in_tready), .s_data(in_tdata), .s_first(in_tuser),
    .q_valid(f_valid), .q_ready(f_ready), .q_item(f_item)
  );

  bew_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk, .rst_n,
    .w_valid(f_valid), .w_ready(f_ready), .w_item(f_item),
    .r_valid(b_valid), .r_ready(b_ready), .r_item(b_item)
  );

  bew_back u_back (
    .clk, .rst_n, .q_valid(b_valid), .q_ready(b_ready), .q_item(b_item),
    .r_valid(out_tvalid), .r_ready(out_tready), .r_data(res)
  );

  // pack with event_res in the lowest bits
  assign rs = res;
  assign out_tdata = {2'b00, rs.count, rs.data_size, rs.data_off, rs.name_len,
                      rs.name_off, rs.etype, rs.ev};

endmodule

// ===== src/bew_front.sv =====
module bew_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en64,
  input  logic            en128,
  input  logic            s_valid,
  output logic            s_ready,
  input  logic [7:0]      s_data,
  input  logic            s_first,
  output logic            q_valid,
  input  logic            q_ready,
  output bew_pkg::item_t  q_item
);

  bew_pkg::item_t item_r, item_nxt;
  logic           vld_r, vld_nxt;
  logic           ok;
  logic           fx;
  logic [4:0]     fs;

  always_comb begin
    ok = 1'b0;
    fx = 1'b0;
    fs = 5'd0;
    case (s_data)
      bew_pkg::T_DOUBLE: begin ok = 1'b1; fx = 1'b1; fs = 5'd8; end
      bew_pkg::T_STRING, bew_pkg::T_DOC, bew_pkg::T_ARRAY, bew_pkg::T_BINARY: ok = 1'b1;
      bew_pkg::T_BOOL:   begin ok = 1'b1; fx = 1'b1; fs = 5'd1; end
      bew_pkg::T_NULL:   begin ok = 1'b1; fx = 1'b1; fs = 5'd0; end
      bew_pkg::T_INT32:  begin ok = 1'b1; fx = 1'b1; fs = 5'd4; end
      bew_pkg::T_UINT64, bew_pkg::T_INT64: begin ok = en64; fx = 1'b1; fs = 5'd8; end
      bew_pkg::T_DEC128: begin ok = en128; fx = 1'b1; fs = 5'd16; end
      default: ok = 1'b0;
    endcase
  end

  assign s_ready = !vld_r || q_ready;
  assign q_valid = vld_r;
  assign q_item  = item_r;

  always_comb begin
    vld_nxt  = vld_r;
    item_nxt = item_r;
    if (s_ready) begin
      vld_nxt  = s_valid;
      item_nxt = '{data: s_data, first: s_first, type_ok: ok, fixed: fx, fsize: fs};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    item_r <= item_nxt;
  end

endmodule

// ===== src/bew_queue.sv =====
module bew_queue #(
  parameter int DEPTH = bew_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            w_valid,
  output logic            w_ready,
  input  bew_pkg::item_t  w_item,
  output logic            r_valid,
  input  logic            r_ready,
  output bew_pkg::item_t  r_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  bew_pkg::item_t     mem_r [DEPTH];
  logic [AW-1:0]      wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]        cnt_r, cnt_nxt;
  logic               wr, rd;

  assign w_ready = cnt_r != AW'(0) + (AW+1)'(DEPTH);
  assign r_valid = cnt_r != '0;
  assign r_item  = mem_r[rp_r];
  assign wr = w_valid && w_ready;
  assign rd = r_valid && r_ready;

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
    inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wp_nxt  = wr ? inc(wp_r) : wp_r;
    rp_nxt  = rd ? inc(rp_r) : rp_r;
    cnt_nxt = cnt_r + (AW+1)'(wr) - (AW+1)'(rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (wr) mem_r[wp_r] <= w_item;
  end

endmodule

// ===== src/bew_back.sv =====
module bew_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  output logic                      q_ready,
  input  bew_pkg::item_t            q_item,
  output logic                      r_valid,
  input  logic                      r_ready,
  output logic [bew_pkg::RES_W-1:0] r_data
);

  bew_pkg::phase_t  ph_r, ph_nxt;
  logic [31:0]      dlen_r, dlen_nxt, pos_r, pos_nxt, acc_r, acc_nxt;
  logic [1:0]       fbi_r, fbi_nxt;
  logic [7:0]       ty_r, ty_nxt;
  logic [31:0]      noff_r, noff_nxt, nlen_r, nlen_nxt, doff_r, doff_nxt;
  logic [31:0]      dsz_r, dsz_nxt, skip_r, skip_nxt, cnt_r, cnt_nxt;
  logic             ov_r, ov_nxt;
  bew_pkg::result_t res_r, res_nxt;

  logic             take, emit;
  bew_pkg::result_t res;
  bew_pkg::phase_t  ph;
  logic [31:0]      off, posn, accv, sk;
  logic [32:0]      endp;
  logic [7:0]       b;

  assign q_ready = !ov_r || r_ready;
  assign take    = q_valid && q_ready;
  assign r_valid = ov_r;
  assign r_data  = res_r;

  always_comb begin
    ph_nxt = ph_r; dlen_nxt = dlen_r; pos_nxt = pos_r; acc_nxt = acc_r;
    fbi_nxt = fbi_r; ty_nxt = ty_r; noff_nxt = noff_r; nlen_nxt = nlen_r;
    doff_nxt = doff_r; dsz_nxt = dsz_r; skip_nxt = skip_r; cnt_nxt = cnt_r;
    emit = 1'b0;
    res = '0;
    ph = ph_r;
    b = q_item.data;
    off = pos_r; posn = pos_r + 32'd1;
    accv = acc_r; endp = '0; sk = skip_r;
    if (take) begin
      if (q_item.first) begin
        ph = bew_pkg::PH_DOCLEN;
        off = '0; posn = 32'd1; accv = '0;
        fbi_nxt = '0; ty_nxt = '0; noff_nxt = '0; nlen_nxt = '0;
        doff_nxt = '0; dsz_nxt = '0; skip_nxt = '0; cnt_nxt = '0; dlen_nxt = '0;
        sk = '0;
      end
      ph_nxt = ph;
      res.count = cnt_nxt[30:0];
      if (ph != bew_pkg::PH_IDLE) begin
        pos_nxt = posn;
        accv = accv | (32'(b) << {(q_item.first ? 2'd0 : fbi_r), 3'b000});
        if (ph == bew_pkg::PH_DOCLEN) begin
          acc_nxt = accv;
          if ((q_item.first ? 2'd0 : fbi_r) != 2'd3) begin
            fbi_nxt = (q_item.first ? 2'd0 : fbi_r) + 2'd1;
          end else begin
            fbi_nxt = '0;
            dlen_nxt = accv;
            if (accv[31] || accv < 32'd5) begin
              emit = 1'b1; res.ev = bew_pkg::EV_SHORT; ph_nxt = bew_pkg::PH_IDLE;
            end else ph_nxt = bew_pkg::PH_TYPE;
          end
        end else if (off >= dlen_r) begin
          emit = 1'b1; res.ev = bew_pkg::EV_OVERRUN; ph_nxt = bew_pkg::PH_IDLE;
        end else begin
          case (ph)
            bew_pkg::PH_TYPE: begin
              if (b == 8'd0) begin
                emit = 1'b1; res.ev = bew_pkg::EV_END; ph_nxt = bew_pkg::PH_IDLE;
              end else if (!q_item.type_ok) begin
                emit = 1'b1; res.ev = bew_pkg::EV_BADTYPE; ph_nxt = bew_pkg::PH_IDLE;
              end else begin
                ty_nxt = b; noff_nxt = posn; ph_nxt = bew_pkg::PH_NAME;
              end
            end
            bew_pkg::PH_NAME: begin
              if (b == 8'd0) begin
                nlen_nxt = off - noff_r;
                doff_nxt = posn;
                if (!(ty_r == bew_pkg::T_STRING || ty_r == bew_pkg::T_DOC ||
                      ty_r == bew_pkg::T_ARRAY || ty_r == bew_pkg::T_BINARY)) begin
                  // fixed size kept from the type byte classification
                  dsz_nxt = 32'(skip_r[4:0]);
                  endp = {1'b0, posn} + 33'(skip_r[4:0]);
                  if (endp > {1'b0, dlen_r}) begin
                    emit = 1'b1; res.ev = bew_pkg::EV_OVERRUN; ph_nxt = bew_pkg::PH_IDLE;
                  end else if (skip_r[4:0] == 5'd0) begin
                    cnt_nxt = cnt_r + 32'd1; emit = 1'b1; ph_nxt = bew_pkg::PH_TYPE;
                  end else ph_nxt = bew_pkg::PH_SKIP;
                end else begin
                  fbi_nxt = '0; acc_nxt = '0; ph_nxt = bew_pkg::PH_LENF;
                end
              end
            end
            bew_pkg::PH_LENF: begin
              acc_nxt = accv;
              if (fbi_r != 2'd3) fbi_nxt = fbi_r + 2'd1;
              else begin
                fbi_nxt = '0;
                ph_nxt = bew_pkg::PH_SKIP;
                if (ty_r == bew_pkg::T_STRING) begin
                  doff_nxt = posn; dsz_nxt = accv - 32'd1; skip_nxt = accv;
                  endp = {1'b0, posn} + {1'b0, accv};
                  if (accv[31] || accv == 32'd0) begin
                    emit = 1'b1; res.ev = bew_pkg::EV_BADTYPE; ph_nxt = bew_pkg::PH_IDLE;
                  end
                end else if (ty_r == bew_pkg::T_BINARY) begin
                  dsz_nxt = accv;
                  endp = {1'b0, posn} + 33'd1 + {1'b0, accv};
                  ph_nxt = bew_pkg::PH_SUBTYPE;
                  if (accv[31]) begin
                    emit = 1'b1; res.ev = bew_pkg::EV_BADTYPE; ph_nxt = bew_pkg::PH_IDLE;
                  end
                end else begin
                  dsz_nxt = accv; skip_nxt = accv - 32'd4;
                  endp = {1'b0, posn} + {1'b0, accv - 32'd4};
                  if (accv[31] || accv < 32'd5) begin
                    emit = 1'b1; res.ev = bew_pkg::EV_BADTYPE; ph_nxt = bew_pkg::PH_IDLE;
                  end
                end
                if (!emit && endp > {1'b0, dlen_r}) begin
                  emit = 1'b1; res.ev = bew_pkg::EV_OVERRUN; ph_nxt = bew_pkg::PH_IDLE;
                end
              end
            end
            bew_pkg::PH_SUBTYPE: begin
              if (b != 8'd0) begin
                emit = 1'b1; res.ev = bew_pkg::EV_SUBTYPE; ph_nxt = bew_pkg::PH_IDLE;
              end else begin
                doff_nxt = posn;
                if (dsz_r == 32'd0) begin
                  cnt_nxt = cnt_r + 32'd1; emit = 1'b1; ph_nxt = bew_pkg::PH_TYPE;
                end else begin
                  skip_nxt = dsz_r; ph_nxt = bew_pkg::PH_SKIP;
                end
              end
            end
            bew_pkg::PH_SKIP: begin
              if (sk != 32'd0) sk = sk - 32'd1;
              skip_nxt = sk;
              if (sk == 32'd0) begin
                cnt_nxt = cnt_r + 32'd1; emit = 1'b1; ph_nxt = bew_pkg::PH_TYPE;
              end
            end
            default: ph_nxt = bew_pkg::PH_IDLE;
          endcase
          if (ph == bew_pkg::PH_TYPE && !emit && q_item.type_ok) begin
            // stash fixed size until the name ends
            skip_nxt = 32'(q_item.fsize);
          end
        end
        if (emit) begin
          res.count = cnt_nxt[30:0];
          if (res.ev == bew_pkg::EV_ELEM) begin
            res.etype     = ty_r;
            res.name_off  = noff_r[30:0];
            res.name_len  = nlen_nxt[30:0];
            res.data_off  = doff_nxt[30:0];
            res.data_size = dsz_nxt[30:0];
          end
        end
      end
    end
    ov_nxt  = (ov_r && !r_ready) || emit;
    res_nxt = emit ? res : res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= bew_pkg::PH_IDLE;
      ov_r <= 1'b0;
      dlen_r <= '0; pos_r <= '0; acc_r <= '0; fbi_r <= '0; ty_r <= '0;
      noff_r <= '0; nlen_r <= '0; doff_r <= '0; dsz_r <= '0; skip_r <= '0;
      cnt_r <= '0;
    end else begin
      ph_r <= ph_nxt;
      ov_r <= ov_nxt;
      dlen_r <= dlen_nxt; pos_r <= pos_nxt; acc_r <= acc_nxt; fbi_r <= fbi_nxt;
      ty_r <= ty_nxt; noff_r <= noff_nxt; nlen_r <= nlen_nxt; doff_r <= doff_nxt;
      dsz_r <= dsz_nxt; skip_r <= skip_nxt; cnt_r <= cnt_nxt;
    end
    res_r <= res_nxt;
  end

endmodule

// ===== src/bew_checker.sv =====
`include "assert_macros.svh"

module bew_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [167:0] out_tdata,
  input logic         cfg_pready
);

  `BEW_ASSERT_IMP(a_evt_range, out_tvalid, out_tdata[2:0] <= 3'd5, "bad event code")
  `BEW_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result dropped")
  `BEW_ASSERT_IMP(a_err_zero, out_tvalid && out_tdata[2:0] != 3'd0, out_tdata[134:3] == '0, "error fields not zero")
  `BEW_ASSERT_IMP(a_pready, 1'b1, cfg_pready, "pready low")

endmodule

bind bson_element_walker_core bew_checker u_chk (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tdata, .cfg_pready
);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

class walker_scoreboard;
  // register copies
  bit          int64_on = 1'b1;
  bit          dec128_on = 1'b1;
  // parser state
  bew_pkg::phase_t ph = bew_pkg::PH_IDLE;
  logic [31:0] doc_len, pos, acc, cur_type, name_off, name_len;
  logic [31:0] data_off, data_size, skip_left, elem_cnt;
  logic [1:0]  word_idx;
  bew_pkg::result_t pending_results[$];
  int          n_elem, n_end, n_err, n_fail;

  function void clear_state();
    ph = bew_pkg::PH_IDLE;
    doc_len = 0; pos = 0; acc = 0; cur_type = 0; name_off = 0; name_len = 0;
    data_off = 0; data_size = 0; skip_left = 0; elem_cnt = 0; word_idx = 0;
  endfunction

  function new();
    clear_state();
  endfunction

  function bit type_known(logic [7:0] t);
    case (t)
      bew_pkg::T_DOUBLE, bew_pkg::T_STRING, bew_pkg::T_DOC, bew_pkg::T_ARRAY,
      bew_pkg::T_BINARY, bew_pkg::T_BOOL, bew_pkg::T_NULL, bew_pkg::T_INT32: return 1'b1;
      bew_pkg::T_UINT64, bew_pkg::T_INT64: return int64_on;
      bew_pkg::T_DEC128: return dec128_on;
      default: return 1'b0;
    endcase
  endfunction

  // fixed payload size, -1 for length-prefixed kinds
  function int payload_size(logic [7:0] t);
    case (t)
      bew_pkg::T_DOUBLE, bew_pkg::T_UINT64, bew_pkg::T_INT64: return 8;
      bew_pkg::T_BOOL: return 1;
      bew_pkg::T_NULL: return 0;
      bew_pkg::T_INT32: return 4;
      bew_pkg::T_DEC128: return 16;
      default: return -1;
    endcase
  endfunction

  function void push(logic [2:0] ev, logic [31:0] ty, logic [31:0] no, logic [31:0] nl,
                     logic [31:0] dof, logic [31:0] ds);
    bew_pkg::result_t r;
    r.ev = ev; r.etype = ty[7:0]; r.name_off = no[30:0]; r.name_len = nl[30:0];
    r.data_off = dof[30:0]; r.data_size = ds[30:0]; r.count = elem_cnt[30:0];
    pending_results.push_back(r);
    if (ev == bew_pkg::EV_ELEM) n_elem++;
    else if (ev == bew_pkg::EV_END) n_end++;
    else n_err++;
  endfunction

  function void abort(logic [2:0] code);
    push(code, 0, 0, 0, 0, 0);
    ph = bew_pkg::PH_IDLE;
  endfunction

  function void close_element();
    elem_cnt++;
    push(bew_pkg::EV_ELEM, cur_type, name_off, name_len, data_off, data_size);
    ph = bew_pkg::PH_TYPE;
  endfunction

  // one accepted input transaction
  function void note_byte(logic [7:0] b, logic first);
    logic [31:0] off;
    longint unsigned stop;
    int fs;
    if (first) begin
      clear_state();
      ph = bew_pkg::PH_DOCLEN;
    end
    if (ph == bew_pkg::PH_IDLE) return;
    off = pos;
    pos++;
    if (ph == bew_pkg::PH_DOCLEN) begin
      acc |= 32'(b) << (8 * word_idx);
      if (word_idx < 3) begin
        word_idx++;
        return;
      end
      word_idx = 0;
      doc_len = acc;
      if (doc_len[31] || doc_len < 5) abort(bew_pkg::EV_SHORT);
      else ph = bew_pkg::PH_TYPE;
      return;
    end
    if (off >= doc_len) begin
      abort(bew_pkg::EV_OVERRUN);
      return;
    end
    case (ph)
      bew_pkg::PH_TYPE: begin
        if (b == 0) begin
          push(bew_pkg::EV_END, 0, 0, 0, 0, 0);
          ph = bew_pkg::PH_IDLE;
        end else if (!type_known(b)) begin
          abort(bew_pkg::EV_BADTYPE);
        end else begin
          cur_type = b;
          name_off = pos;
          ph = bew_pkg::PH_NAME;
        end
      end
      bew_pkg::PH_NAME: begin
        if (b != 0) return;
        name_len = off - name_off;
        fs = payload_size(cur_type[7:0]);
        data_off = pos;
        if (fs < 0) begin
          word_idx = 0;
          acc = 0;
          ph = bew_pkg::PH_LENF;
          return;
        end
        data_size = fs;
        if (longint'(pos) + fs > longint'(doc_len)) abort(bew_pkg::EV_OVERRUN);
        else if (fs == 0) close_element();
        else begin
          skip_left = fs;
          ph = bew_pkg::PH_SKIP;
        end
      end
      bew_pkg::PH_LENF: begin
        acc |= 32'(b) << (8 * word_idx);
        if (word_idx < 3) begin
          word_idx++;
          return;
        end
        word_idx = 0;
        if (cur_type[7:0] == bew_pkg::T_STRING) begin
          if (acc[31] || acc < 1) begin
            abort(bew_pkg::EV_BADTYPE);
            return;
          end
          data_off = pos;
          data_size = acc - 1;
          skip_left = acc;
          stop = longint'(pos) + acc;
        end else if (cur_type[7:0] == bew_pkg::T_BINARY) begin
          if (acc[31]) begin
            abort(bew_pkg::EV_BADTYPE);
            return;
          end
          data_size = acc;
          stop = longint'(pos) + 1 + acc;
          if (stop > longint'(doc_len)) abort(bew_pkg::EV_OVERRUN);
          else ph = bew_pkg::PH_SUBTYPE;
          return;
        end else begin
          // nested document or array, skipped whole
          if (acc[31] || acc < 5) begin
            abort(bew_pkg::EV_BADTYPE);
            return;
          end
          data_size = acc;
          skip_left = acc - 4;
          stop = longint'(pos) + skip_left;
        end
        if (stop > longint'(doc_len)) abort(bew_pkg::EV_OVERRUN);
        else ph = bew_pkg::PH_SKIP;
      end
      bew_pkg::PH_SUBTYPE: begin
        if (b != 0) abort(bew_pkg::EV_SUBTYPE);
        else begin
          data_off = pos;
          if (data_size == 0) close_element();
          else begin
            skip_left = data_size;
            ph = bew_pkg::PH_SKIP;
          end
        end
      end
      bew_pkg::PH_SKIP: begin
        if (skip_left > 0) skip_left--;
        if (skip_left == 0) close_element();
      end
      default: ph = bew_pkg::PH_IDLE;
    endcase
  endfunction

  function void check_result(logic [167:0] d);
    bew_pkg::result_t e;
    if (pending_results.size() == 0) begin
      $error("unexpected result transaction %h", d);
      n_fail++;
      return;
    end
    e = pending_results.pop_front();
    if (d[2:0] != e.ev) begin
      $error("event_res: expected %0d got %0d", e.ev, d[2:0]); n_fail++;
    end
    if (d[10:3] != e.etype) begin
      $error("elem_type: expected %0h got %0h", e.etype, d[10:3]); n_fail++;
    end
    if (d[41:11] != e.name_off) begin
      $error("name_offset: expected %0d got %0d", e.name_off, d[41:11]); n_fail++;
    end
    if (d[72:42] != e.name_len) begin
      $error("name_length: expected %0d got %0d", e.name_len, d[72:42]); n_fail++;
    end
    if (d[103:73] != e.data_off) begin
      $error("data_offset: expected %0d got %0d", e.data_off, d[103:73]); n_fail++;
    end
    if (d[134:104] != e.data_size) begin
      $error("data_size: expected %0d got %0d", e.data_size, d[134:104]); n_fail++;
    end
    if (d[165:135] != e.count) begin
      $error("elem_count: expected %0d got %0d", e.count, d[165:135]); n_fail++;
    end
  endfunction
endclass

module tb;
  logic         clk = 1'b0;
  logic         rst_n;
  logic         in_tvalid, in_tready;
  logic [7:0]   in_tdata;
  logic         in_tuser;
  logic         out_tvalid, out_tready;
  logic [167:0] out_tdata;
  logic         cfg_psel, cfg_penable, cfg_pwrite;
  logic [2:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata, cfg_prdata;
  logic         cfg_pready;

  walker_scoreboard sb = new();

  // document under construction and the byte stream built from it
  logic [7:0] body[$];
  logic [7:0] stream_bytes[$];
  bit         stream_marks[$];
  int         bytes_sent;
  int         cycle_count = 0;
  bit         in_burst, out_burst;

  localparam logic [7:0] ELEM_KINDS[11] = '{bew_pkg::T_DOUBLE, bew_pkg::T_STRING,
                                            bew_pkg::T_DOC, bew_pkg::T_ARRAY,
                                            bew_pkg::T_BINARY, bew_pkg::T_BOOL,
                                            bew_pkg::T_NULL, bew_pkg::T_INT32,
                                            bew_pkg::T_UINT64, bew_pkg::T_INT64,
                                            bew_pkg::T_DEC128};

  always #6 clk = ~clk;

  bson_element_walker_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 600000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // --- stream building helpers ---
  task automatic put_word(ref logic [7:0] q[$], input logic [31:0] w);
    for (int i = 0; i < 4; i++) q.push_back(w[8*i +: 8]);
  endtask

  task automatic add_name();
    int n;
    n = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) body.push_back(8'($urandom_range(1, 255)));
    body.push_back(8'h00);
  endtask

  // one element of kind t appended to the body, well formed when t is a known kind
  task automatic add_element(logic [7:0] t);
    int n;
    body.push_back(t);
    add_name();
    case (t)
      bew_pkg::T_STRING: begin
        n = $urandom_range(1, 6);
        put_word(body, n);
        for (int i = 0; i < n - 1; i++) body.push_back(8'($urandom));
        body.push_back(8'h00);
      end
      bew_pkg::T_DOC, bew_pkg::T_ARRAY: begin
        n = $urandom_range(5, 10);
        put_word(body, n);
        for (int i = 0; i < n - 4; i++) body.push_back(8'($urandom));
      end
      bew_pkg::T_BINARY: begin
        n = $urandom_range(0, 5);
        put_word(body, n);
        body.push_back(8'h00);
        for (int i = 0; i < n; i++) body.push_back(8'($urandom));
      end
      default: begin
        n = sb.payload_size(t);
        for (int i = 0; i < n; i++) body.push_back(8'($urandom));
      end
    endcase
  endtask

  // size word, then body, first byte marked
  task automatic emit_doc(logic [31:0] size);
    logic [7:0] w[$];
    put_word(w, size);
    foreach (w[i]) begin
      stream_bytes.push_back(w[i]);
      stream_marks.push_back(i == 0);
    end
    foreach (body[i]) begin
      stream_bytes.push_back(body[i]);
      stream_marks.push_back(1'b0);
    end
    body.delete();
  endtask

  // --- drivers ---
  task automatic send_byte(logic [7:0] b, bit first);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= first;
    do @(posedge clk); while (!in_tready);
    sb.note_byte(b, first);
    bytes_sent++;
  endtask

  task automatic flush_stream();
    foreach (stream_bytes[i]) begin
      if (stream_marks[i]) in_burst = ($urandom_range(0, 3) == 0);
      send_byte(stream_bytes[i], stream_marks[i]);
    end
    stream_bytes.delete();
    stream_marks.delete();
  endtask

  // registers only change once the block has drained
  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    in_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= 3'(idx) << 2;
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == bew_pkg::REG_INT64) sb.int64_on = val[0];
    else sb.dec128_on = val[0];
  endtask

  // random documents, well formed or damaged
  task automatic random_docs(int n_bytes);
    int target, n_elems, size, k;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      n_elems = $urandom_range(0, 6);
      for (int e = 0; e < n_elems; e++) begin
        if ($urandom_range(0, 19) == 0) add_element(8'($urandom));
        else add_element(ELEM_KINDS[$urandom_range(0, 10)]);
      end
      body.push_back(8'h00);
      size = body.size() + 4;
      k = $urandom_range(0, 9);
      case (k)
        0: body[$urandom_range(0, body.size() - 1)] = 8'($urandom);
        1: size = $urandom_range(0, size - 1);
        2: size = size + $urandom_range(1, 8);
        3: size = $urandom;
        4: body.pop_back();
        default: ;
      endcase
      emit_doc(size);
      // an early restart inside the document
      if (k == 5 && stream_marks.size() > 5)
        stream_marks[$urandom_range(1, stream_marks.size() - 1)] = 1'b1;
      // stray bytes between documents
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 4)) begin
          stream_bytes.push_back(8'($urandom));
          stream_marks.push_back(1'b0);
        end
      flush_stream();
    end
  endtask

  task automatic directed_docs();
    // minimal document: size then end
    body.push_back(8'h00);
    emit_doc(5);
    // size too small, negative size
    emit_doc(4);
    emit_doc(32'h8000_0000);
    // every element kind in one document
    foreach (ELEM_KINDS[i]) add_element(ELEM_KINDS[i]);
    body.push_back(8'h00);
    emit_doc(body.size() + 4);
    // unknown type with extreme name byte
    body = '{8'h07, 8'hFF, 8'h00};
    emit_doc(20);
    // string of length zero
    body = '{bew_pkg::T_STRING, 8'h61, 8'h00};
    put_word(body, 0);
    emit_doc(20);
    // nested document shorter than its header
    body = '{bew_pkg::T_DOC, 8'h00};
    put_word(body, 4);
    emit_doc(20);
    // negative binary length, then nonzero subtype
    body = '{bew_pkg::T_BINARY, 8'h00};
    put_word(body, 32'hFFFF_FFFF);
    emit_doc(20);
    body = '{bew_pkg::T_BINARY, 8'h00};
    put_word(body, 2);
    body.push_back(8'h01);
    emit_doc(20);
    // fixed element running past the document
    body = '{bew_pkg::T_DOUBLE, 8'h00, 8'h11};
    emit_doc(8);
    // element ends exactly at the size, terminator falls beyond it
    body = '{bew_pkg::T_INT32, 8'h61, 8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h00};
    emit_doc(11);
    // restart in the middle of a document
    body = '{bew_pkg::T_BOOL, 8'h62, 8'h00};
    emit_doc(40);
    body = '{bew_pkg::T_NULL, 8'h00, 8'h00};
    emit_doc(7);
    flush_stream();
  endtask

  // result side, random stalls
  initial begin
    int gap;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 15) == 0) out_burst = ~out_burst;
      gap = out_burst ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_result(out_tdata);
    end
  end

  // main sequence
  initial begin
    bytes_sent  = 0;
    in_burst    = 1'b0;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: both extended kinds on
    directed_docs();
    random_docs(250);
    // extended kinds off: they must be rejected
    cfg_write(bew_pkg::REG_INT64, 32'd0);
    cfg_write(bew_pkg::REG_DEC128, 32'd0);
    body = '{bew_pkg::T_INT64, 8'h00};
    emit_doc(30);
    body = '{bew_pkg::T_DEC128, 8'h00};
    emit_doc(30);
    flush_stream();
    random_docs(250);
    cfg_write(bew_pkg::REG_INT64, 32'd1);
    random_docs(200);
    cfg_write(bew_pkg::REG_INT64, 32'd0);
    cfg_write(bew_pkg::REG_DEC128, 32'd1);
    random_docs(200);
    cfg_write(bew_pkg::REG_INT64, 32'hFFFF_FFFF);
    random_docs(100);

    in_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("covered %0d input bytes: %0d elements, %0d document ends, %0d errors",
             bytes_sent, sb.n_elem, sb.n_end, sb.n_err);
    $display("checked under four register settings with random gaps on both sides");
    if (sb.n_fail == 0 && sb.pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ===== bson_element_walker_core.f =====
+incdir+src
src/bew_pkg.sv
src/bew_front.sv
src/bew_queue.sv
src/bew_back.sv
src/bson_element_walker_core.sv
src/bew_checker.sv
bench/tb.sv
